FILE: hw/rtl/btf_pkg.sv
`timescale 1ns / 1ps

package btf_pkg;

	// Field widths of the command and result channels.
	localparam int CMD_W = 3;
	localparam int BTN_W = 5;
	localparam int KIND_W = 2;
	localparam int VAL_W = 2;
	localparam int MODE_W = 2;

	// Configuration port.
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 6;
	localparam int COUNT_W = 6;

	localparam int MAX_BUTTONS_DEF = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALERTS_ENABLED = 1'd1;

	localparam logic [COUNT_W-1:0] BUTTON_COUNT_RST = 6'd32;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_SET_LEVEL = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REPORT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET_MOMENTARY = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SET_TOGGLE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ALL_MOMENTARY = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ALL_TOGGLE = 3'd5;

	// Button modes, also used as alert values.
	localparam logic [MODE_W-1:0] MODE_MOMENTARY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TOGGLE_OFF = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TOGGLE_ON = 2'd2;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALERT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

endpackage

FILE: hw/rtl/btf_req_if.sv
`timescale 1ns / 1ps

interface btf_req_if
	import btf_pkg::*;
();
	logic valid;
	logic ready;
	logic [CMD_W-1:0] command;
	logic [BTN_W-1:0] button_index;
	logic level_or_state;

	modport source(output valid, output command, output button_index,
		output level_or_state, input ready);
	modport sink(input valid, input command, input button_index,
		input level_or_state, output ready);
endinterface

FILE: hw/rtl/btf_rsp_if.sv
`timescale 1ns / 1ps

interface btf_rsp_if
	import btf_pkg::*;
();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic [BTN_W-1:0] button_number;
	logic [VAL_W-1:0] value;
	logic last;

	modport source(output valid, output kind, output button_number,
		output value, output last, input ready);
	modport sink(input valid, input kind, input button_number,
		input value, input last, output ready);
endinterface

FILE: hw/rtl/button_toggle_mode_filter_core.sv
`timescale 1ns / 1ps

// Button latch with momentary and toggle modes. One command item is taken
// at a time; the block is not ready while an item is in work. Set-level,
// set-momentary and set-toggle act on a single button; the unused command
// codes change no state and give no result. Report, all-momentary and
// all-toggle walk the active buttons (button_count, limited to MAX_BUTTONS)
// one per cycle, unless a result waits for a full result path; a toggle
// button that emits both an alert and a change report is visited again for
// the report. The walk goes over the per-button state registers through a
// single read/write address. Results leave through a one-deep holding stage
// and an output register, so the last flag is known before the final result
// is shown.
module button_toggle_mode_filter_core
	import btf_pkg::*;
#(
	parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
	input logic clk,
	input logic arst_n,
	btf_req_if.sink req,
	btf_rsp_if.source rsp,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDXW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
	localparam int CNTW = $clog2(MAX_BUTTONS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SINGLE = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [CMD_W-1:0] cmd_q;
	logic [BTN_W-1:0] idx_q;
	logic bit_q;
	logic [CNTW-1:0] i_q;
	logic phase_q;

	logic [COUNT_W-1:0] count_q;
	logic alerts_q;

	logic lvl_now_q [MAX_BUTTONS];
	logic lvl_bef_q [MAX_BUTTONS];
	logic [MODE_W-1:0] mode_q [MAX_BUTTONS];

	logic pend_valid_q;
	logic [KIND_W-1:0] pend_kind_q;
	logic [BTN_W-1:0] pend_btn_q;
	logic [VAL_W-1:0] pend_val_q;

	logic rsp_valid_q;
	logic [KIND_W-1:0] rsp_kind_q;
	logic [BTN_W-1:0] rsp_btn_q;
	logic [VAL_W-1:0] rsp_val_q;
	logic rsp_last_q;

	logic [COUNT_W-1:0] cnt;
	logic [IDXW-1:0] addr;
	logic now_b;
	logic bef_b;
	logic [MODE_W-1:0] mode_b;
	logic [MODE_W-1:0] tgl_mode;
	logic [MODE_W-1:0] next_tgl;
	logic scan_end;
	logic idx_err;
	logic out_free;
	logic go;

	logic gen_valid;
	logic [KIND_W-1:0] gen_kind;
	logic [VAL_W-1:0] gen_val;
	logic [BTN_W-1:0] gen_btn;
	logic step_done;
	logic step_alert;
	logic lvl_now_we;
	logic lvl_bef_we;
	logic mode_we;
	logic [MODE_W-1:0] mode_wd;

	logic gen_fire;
	logic mv_mid;
	logic mv_flush;

	assign cnt = (count_q > COUNT_W'(MAX_BUTTONS)) ? COUNT_W'(MAX_BUTTONS) : count_q;
	assign addr = (state_q == ST_SCAN) ? i_q[IDXW-1:0] : idx_q[IDXW-1:0];
	assign now_b = lvl_now_q[addr];
	assign bef_b = lvl_bef_q[addr];
	assign mode_b = mode_q[addr];
	assign tgl_mode = bit_q ? MODE_TOGGLE_ON : MODE_TOGGLE_OFF;
	assign next_tgl = (mode_b == MODE_TOGGLE_ON) ? MODE_TOGGLE_OFF : MODE_TOGGLE_ON;
	assign scan_end = COUNT_W'(i_q) >= cnt;
	assign idx_err = COUNT_W'(idx_q) >= cnt;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign gen_btn = (state_q == ST_SCAN) ? BTN_W'(i_q) : idx_q;

	// One button (or one single-button command) is evaluated per cycle, unless a result waits for a full result path.
	always_comb begin
		gen_valid = 1'b0;
		gen_kind = KIND_CHANGE;
		gen_val = '0;
		step_done = 1'b0;
		step_alert = 1'b0;
		lvl_now_we = 1'b0;
		lvl_bef_we = 1'b0;
		mode_we = 1'b0;
		mode_wd = mode_b;
		if (state_q == ST_SCAN && !scan_end) begin
			case (cmd_q)
				CMD_REPORT: begin
					if (mode_b == MODE_MOMENTARY) begin
						gen_valid = now_b != bef_b;
						gen_val = {1'b0, now_b};
						step_done = 1'b1;
					end else if (now_b && !bef_b) begin
						// A toggle with alerts on gives the alert first and the
						// change report after it.
						if (alerts_q && !phase_q) begin
							gen_valid = 1'b1;
							gen_kind = KIND_ALERT;
							gen_val = next_tgl;
							step_alert = 1'b1;
						end else begin
							gen_valid = 1'b1;
							gen_val = (mode_b == MODE_TOGGLE_ON) ? 2'd0 : 2'd1;
							mode_we = 1'b1;
							mode_wd = next_tgl;
							step_done = 1'b1;
						end
					end else begin
						step_done = 1'b1;
					end
					lvl_bef_we = step_done;
				end
				CMD_ALL_MOMENTARY: begin
					if (mode_b != MODE_MOMENTARY) begin
						mode_we = 1'b1;
						mode_wd = MODE_MOMENTARY;
						gen_valid = alerts_q;
						gen_kind = KIND_ALERT;
						gen_val = MODE_TOGGLE_OFF;
					end
					step_done = 1'b1;
				end
				CMD_ALL_TOGGLE: begin
					if (mode_b == MODE_MOMENTARY) begin
						mode_we = 1'b1;
						mode_wd = tgl_mode;
						gen_valid = alerts_q;
						gen_kind = KIND_ALERT;
						gen_val = tgl_mode;
					end
					step_done = 1'b1;
				end
				default: begin
					step_done = 1'b1;
				end
			endcase
		end else if (state_q == ST_SINGLE) begin
			if (idx_err) begin
				gen_valid = 1'b1;
				gen_kind = KIND_ERROR;
			end else begin
				case (cmd_q)
					CMD_SET_LEVEL: begin
						lvl_now_we = 1'b1;
					end
					CMD_SET_MOMENTARY: begin
						mode_we = 1'b1;
						mode_wd = MODE_MOMENTARY;
						gen_valid = alerts_q;
						gen_kind = KIND_ALERT;
						gen_val = MODE_TOGGLE_OFF;
					end
					CMD_SET_TOGGLE: begin
						mode_we = 1'b1;
						mode_wd = tgl_mode;
						gen_valid = alerts_q;
						gen_kind = KIND_ALERT;
						gen_val = tgl_mode;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// A new result can be taken when the holding stage is empty or can pass
	// its item on to the output register.
	assign go = !gen_valid || !pend_valid_q || out_free;
	assign gen_fire = gen_valid && go;
	assign mv_mid = gen_fire && pend_valid_q;
	assign mv_flush = (state_q == ST_FLUSH) && pend_valid_q && out_free;

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			phase_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						i_q <= '0;
						phase_q <= 1'b0;
						if (req.command inside {CMD_REPORT, CMD_ALL_MOMENTARY,
							CMD_ALL_TOGGLE}) begin
							state_q <= ST_SCAN;
						end else if (req.command inside {CMD_SET_LEVEL,
							CMD_SET_MOMENTARY, CMD_SET_TOGGLE}) begin
							state_q <= ST_SINGLE;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_SINGLE: begin
					state_q <= ST_FLUSH;
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_FLUSH;
					end else if (go) begin
						if (step_alert) begin
							phase_q <= 1'b1;
						end else if (step_done) begin
							phase_q <= 1'b0;
							i_q <= i_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q <= req.command;
			idx_q <= req.button_index;
			bit_q <= req.level_or_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= BUTTON_COUNT_RST;
			alerts_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BUTTON_COUNT: count_q <= cfg_data;
				REG_ALERTS_ENABLED: alerts_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_BUTTONS; k++) begin
				lvl_now_q[k] <= 1'b0;
				lvl_bef_q[k] <= 1'b0;
				mode_q[k] <= MODE_MOMENTARY;
			end
		end else if (go) begin
			if (lvl_now_we) begin
				lvl_now_q[addr] <= bit_q;
			end
			if (lvl_bef_we) begin
				lvl_bef_q[addr] <= now_b;
			end
			if (mode_we) begin
				mode_q[addr] <= mode_wd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (gen_fire) begin
				pend_valid_q <= 1'b1;
			end else if (mv_flush) begin
				pend_valid_q <= 1'b0;
			end
			if (mv_mid || mv_flush) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (gen_fire) begin
			pend_kind_q <= gen_kind;
			pend_btn_q <= gen_btn;
			pend_val_q <= gen_val;
		end
		if (mv_mid || mv_flush) begin
			rsp_kind_q <= pend_kind_q;
			rsp_btn_q <= pend_btn_q;
			rsp_val_q <= pend_val_q;
			rsp_last_q <= mv_flush;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.kind = rsp_kind_q;
	assign rsp.button_number = rsp_btn_q;
	assign rsp.value = rsp_val_q;
	assign rsp.last = rsp_last_q;

endmodule
